[rtl/dtc_pkg.sv]
// Shared types and constants of the depth-to-color registration block.
// Used by dtc_front, dtc_back, the top level and the bench; depends on nothing.
package dtc_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_FOCAL     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_CENTER    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROJ_ROW0_LEFT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PROJ_ROW0_RIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PROJ_ROW1_LEFT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PROJ_ROW1_RIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PROJ_ROW2_LEFT  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PROJ_ROW2_RIGHT = 3'd7;

	// Datapath widths
	localparam int DIFF_W = 34;   // col*2^16 - cx
	localparam int NUM_W  = 50;   // diff * depth
	localparam int XMAG_W = 56;   // |diff*depth|*256 + f/2
	localparam int XY_Q_W = 30;   // back-projection quotient bits
	localparam int CNUM_W = 71;   // projected numerator * 256
	localparam int CDEN_W = 63;   // positive projected depth
	localparam int CQ_W   = 20;   // color coordinate, Q12.8
	localparam int Q_DEPTH = 4;

	// Metric scaling: round(v*256/1000) = floor((32*|v| + 62) / 125), by reciprocal
	localparam int MN_W    = 36;   // 32*|value_q8| + 62
	localparam int MR_W    = 31;   // numerator bits below the saturation bound
	localparam int MQ_W    = 24;
	localparam int MREC_SH = 38;
	localparam int MP_W    = MR_W + 32;
	localparam logic [31:0]     MREC       = 32'd2199023256;  // ceil(2^38 / 125)
	localparam logic [MN_W-1:0] MSAT_BOUND = 36'd2097152000;  // 125 * 2^24
	localparam logic [MN_W-1:0] MROUND     = 36'd62;          // 500 / 8, floored

	typedef struct packed {
		logic [9:0]         pixel_col;
		logic [8:0]         pixel_row;
		logic signed [15:0] depth_raw;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] point_x;
		logic signed [23:0] point_y;
		logic signed [23:0] point_z;
		logic [17:0]        color_col;
		logic [16:0]        color_row;
	} out_item_t;

	typedef struct packed {
		logic [31:0]             fx;
		logic [31:0]             fy;
		logic [31:0]             cx;
		logic [31:0]             cy;
		logic [2:0][3:0][31:0]   p;
	} cfg_t;

endpackage

[rtl/dtc_fifo.sv]
// Small register queue with first-word fall-through read.
// Depends on nothing; used by the front and back parts.
module dtc_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = PTR_W + 1;

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             wr_ok, rd_ok;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign wr_ok = wr && !full;
	assign rd_ok = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_ok) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_ok) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr_ok && !rd_ok) cnt_q <= cnt_q + 1'b1;
			else if (rd_ok && !wr_ok) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (wr_ok) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

[rtl/dtc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on nothing; used by the back part.
module dtc_div #(
	parameter int N_W = 56,
	parameter int D_W = 32,
	parameter int Q_W = 30,
	parameter int T_W = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	input  logic [T_W-1:0] tag,
	output logic           out_valid,
	output logic [Q_W-1:0] quo,
	output logic           ovf,
	output logic [T_W-1:0] out_tag
);
	localparam int H_W = N_W - Q_W;
	localparam int C_W = (H_W > D_W) ? H_W : D_W;

	logic           vld_s [Q_W+1];
	logic [D_W-1:0] rem_s [Q_W+1];
	logic [Q_W-1:0] quo_s [Q_W+1];
	logic [Q_W-1:0] low_s [Q_W+1];
	logic [D_W-1:0] den_s [Q_W+1];
	logic           ovf_s [Q_W+1];
	logic [T_W-1:0] tag_s [Q_W+1];
	logic [C_W-1:0] hi_ext;

	assign hi_ext = C_W'(num[N_W-1:Q_W]);

	// Load: quotient overflows when the high part already reaches the divisor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else if (en) vld_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= (hi_ext >= C_W'(den));
			rem_s[0] <= hi_ext[D_W-1:0];
			low_s[0] <= num[Q_W-1:0];
			quo_s[0] <= '0;
			den_s[0] <= den;
			tag_s[0] <= tag;
		end
	end

	// One trial subtract per stage
	for (genvar k = 1; k <= Q_W; k++) begin : g_step
		logic [D_W:0] trial, diff;
		logic         ge;

		always_comb begin
			trial = {rem_s[k-1], low_s[k-1][Q_W-1]};
			diff  = trial - {1'b0, den_s[k-1]};
			ge    = (trial >= {1'b0, den_s[k-1]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else if (en) vld_s[k] <= vld_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
				quo_s[k] <= {quo_s[k-1][Q_W-2:0], ge};
				low_s[k] <= {low_s[k-1][Q_W-2:0], 1'b0};
				den_s[k] <= den_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
				tag_s[k] <= tag_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[Q_W];
	assign quo       = quo_s[Q_W];
	assign ovf       = ovf_s[Q_W];
	assign out_tag   = tag_s[Q_W];

endmodule

[rtl/dtc_front.sv]
// Front part: accepts depth pixels, drops off-grid, out-of-image and zero-depth or zero-focal ones, queues the rest.
// Depends on dtc_pkg and dtc_fifo.
module dtc_front #(
	parameter int STRIDE       = 2,
	parameter int DEPTH_WIDTH  = 640,
	parameter int DEPTH_HEIGHT = 480
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  dtc_pkg::in_item_t pixel,
	input  dtc_pkg::cfg_t     cfg,
	input  logic              q_pop,
	output logic              q_empty,
	output dtc_pkg::in_item_t q_item
);
	import dtc_pkg::*;

	// Divisibility by STRIDE: n*M mod 2^K < M with M = ceil(2^K / STRIDE)
	localparam int GRID_K = 24;
	localparam int PROD_W = GRID_K + 11;
	localparam logic [GRID_K:0] GRID_MUL = (GRID_K + 1)'(((2 ** GRID_K) + STRIDE - 1) / STRIDE);
	localparam int LIM_W = 13;

	logic [PROD_W-1:0] col_prod, row_prod;
	logic              on_grid, in_range, measured, keep, q_push;

	always_comb begin
		col_prod = PROD_W'(pixel.pixel_col) * PROD_W'(GRID_MUL);
		row_prod = PROD_W'(pixel.pixel_row) * PROD_W'(GRID_MUL);
		on_grid  = ({1'b0, col_prod[GRID_K-1:0]} < GRID_MUL)
		        && ({1'b0, row_prod[GRID_K-1:0]} < GRID_MUL);
		in_range = (LIM_W'(pixel.pixel_col) < LIM_W'(DEPTH_WIDTH))
		        && (LIM_W'(pixel.pixel_row) < LIM_W'(DEPTH_HEIGHT));
		measured = (pixel.depth_raw != '0) && (cfg.fx != '0) && (cfg.fy != '0);
		keep     = on_grid && in_range && measured;
	end

	// Queue only beats that can produce a point
	assign q_push = push && !full && keep;

	dtc_fifo #(
		.W     ($bits(in_item_t)),
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (pixel),
		.rd     (q_pop),
		.rdata  (q_item),
		.full   (full),
		.empty  (q_empty)
	);

	a_push_measured: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (pixel.depth_raw != '0) && (cfg.fx != '0) && (cfg.fy != '0))
		else $error("queued a pixel without depth or focal length");

endmodule

[rtl/dtc_back.sv]
// Back part: back-projection, color projection, color division and metric scaling.
// Depends on dtc_pkg, dtc_div and dtc_fifo.
module dtc_back #(
	parameter int COLOR_WIDTH  = 640,
	parameter int COLOR_HEIGHT = 480
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dtc_pkg::cfg_t      cfg,
	input  logic               q_empty,
	output logic               q_pop,
	input  dtc_pkg::in_item_t  q_item,
	output logic               empty,
	input  logic               pop,
	output dtc_pkg::out_item_t result
);
	import dtc_pkg::*;

	localparam int LIM_W = CQ_W - 8 + 1;
	localparam logic [LIM_W-1:0] COL_LIM = LIM_W'(COLOR_WIDTH);
	localparam logic [LIM_W-1:0] ROW_LIM = LIM_W'(COLOR_HEIGHT);

	typedef struct packed {
		logic               sx;
		logic signed [15:0] z;
	} xtag_t;

	typedef struct packed {
		logic               ok;
		logic signed [30:0] x;
		logic signed [30:0] y;
		logic signed [23:0] zq;
	} ctag_t;

	logic      en, out_full, out_wr;
	out_item_t out_item;

	// Whole pipeline holds while the result queue is full
	assign en    = !out_full;
	assign q_pop = en && !q_empty;

	// Stage 1: offset from principal point
	logic                     vld_s1;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;
	logic signed [15:0]       z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= !q_empty;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= $signed({8'b0, q_item.pixel_col, 16'b0}) - $signed({2'b0, cfg.cx});
			dy_s1 <= $signed({9'b0, q_item.pixel_row, 16'b0}) - $signed({2'b0, cfg.cy});
			z_s1  <= q_item.depth_raw;
		end
	end

	// Stage 2: scale by depth
	logic                    vld_s2;
	logic signed [NUM_W-1:0] nx_s2, ny_s2;
	logic signed [15:0]      z_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s2 <= NUM_W'(dx_s1) * NUM_W'(z_s1);
			ny_s2 <= NUM_W'(dy_s1) * NUM_W'(z_s1);
			z_s2  <= z_s1;
		end
	end

	// Round-half-away magnitudes for the focal division
	logic [NUM_W-1:0]  ax, ay;
	logic [XMAG_W-1:0] mag_x, mag_y;
	xtag_t             xt_in, xt_out;

	always_comb begin
		ax       = nx_s2[NUM_W-1] ? NUM_W'(-nx_s2) : NUM_W'(nx_s2);
		ay       = ny_s2[NUM_W-1] ? NUM_W'(-ny_s2) : NUM_W'(ny_s2);
		mag_x    = {ax[XMAG_W-9:0], 8'b0} + XMAG_W'(cfg.fx[31:1]);
		mag_y    = {ay[XMAG_W-9:0], 8'b0} + XMAG_W'(cfg.fy[31:1]);
		xt_in.sx = nx_s2[NUM_W-1];
		xt_in.z  = z_s2;
	end

	logic              xv;
	logic [XY_Q_W-1:0] xq, yq;
	logic              xovf, yovf, ysign;
	logic [$bits(xtag_t)-1:0] xt_vec;

	dtc_div #(.N_W(XMAG_W), .D_W(32), .Q_W(XY_Q_W), .T_W($bits(xtag_t))) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s2),
		.num(mag_x), .den(cfg.fx), .tag(xt_in),
		.out_valid(xv), .quo(xq), .ovf(xovf), .out_tag(xt_vec)
	);

	dtc_div #(.N_W(XMAG_W), .D_W(32), .Q_W(XY_Q_W), .T_W(1)) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s2),
		.num(mag_y), .den(cfg.fy), .tag(ny_s2[NUM_W-1]),
		.out_valid(), .quo(yq), .ovf(yovf), .out_tag(ysign)
	);

	assign xt_out = xt_vec;

	// Stage 4: saturate and restore sign
	logic              vld_s4;
	logic signed [30:0] x_s4, y_s4;
	logic signed [23:0] zq_s4;
	logic [XY_Q_W-1:0] xsat, ysat;

	always_comb begin
		xsat = xovf ? '1 : xq;
		ysat = yovf ? '1 : yq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= xv;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s4  <= xt_out.sx ? -$signed({1'b0, xsat}) : $signed({1'b0, xsat});
			y_s4  <= ysign ? -$signed({1'b0, ysat}) : $signed({1'b0, ysat});
			zq_s4 <= $signed({xt_out.z, 8'b0});
		end
	end

	// Stage 5: projection products
	logic               vld_s5;
	logic signed [62:0] pa_s5 [3];
	logic signed [62:0] pb_s5 [3];
	logic signed [55:0] pc_s5 [3];
	logic signed [30:0] x_s5, y_s5;
	logic signed [23:0] zq_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				pa_s5[r] <= 63'($signed(cfg.p[r][0])) * 63'(x_s4);
				pb_s5[r] <= 63'($signed(cfg.p[r][1])) * 63'(y_s4);
				pc_s5[r] <= 56'($signed(cfg.p[r][2])) * 56'(zq_s4);
			end
			x_s5  <= x_s4;
			y_s5  <= y_s4;
			zq_s5 <= zq_s4;
		end
	end

	// Stage 6: sum each projection row
	logic               vld_s6;
	logic signed [63:0] sum_s6 [3];
	logic signed [30:0] x_s6, y_s6;
	logic signed [23:0] zq_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (en) vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				sum_s6[r] <= 64'(pa_s5[r]) + 64'(pb_s5[r]) + 64'(pc_s5[r])
				           + 64'($signed({cfg.p[r][3], 8'b0}));
			end
			x_s6  <= x_s5;
			y_s6  <= y_s5;
			zq_s6 <= zq_s5;
		end
	end

	// Color division: Q.8 coordinate of X/W and Y/W
	ctag_t             ct_in, ct_out;
	logic [CNUM_W-1:0] cnum_x, cnum_y;
	logic [$bits(ctag_t)-1:0] ct_vec;

	always_comb begin
		ct_in.ok = !sum_s6[2][63] && (sum_s6[2] != '0) && !sum_s6[0][63] && !sum_s6[1][63];
		ct_in.x  = x_s6;
		ct_in.y  = y_s6;
		ct_in.zq = zq_s6;
		cnum_x   = {sum_s6[0][CDEN_W-1:0], 8'b0};
		cnum_y   = {sum_s6[1][CDEN_W-1:0], 8'b0};
	end

	logic            cv, cxovf, cyovf;
	logic [CQ_W-1:0] cxq, cyq;

	dtc_div #(.N_W(CNUM_W), .D_W(CDEN_W), .Q_W(CQ_W), .T_W($bits(ctag_t))) u_div_cx (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s6),
		.num(cnum_x), .den(sum_s6[2][CDEN_W-1:0]), .tag(ct_in),
		.out_valid(cv), .quo(cxq), .ovf(cxovf), .out_tag(ct_vec)
	);

	dtc_div #(.N_W(CNUM_W), .D_W(CDEN_W), .Q_W(CQ_W), .T_W(1)) u_div_cy (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s6),
		.num(cnum_y), .den(sum_s6[2][CDEN_W-1:0]), .tag(1'b0),
		.out_valid(), .quo(cyq), .ovf(cyovf), .out_tag()
	);

	assign ct_out = ct_vec;

	// Drop points with non-positive projected depth or outside the color image; fold 1/1000 into 32/125 with rounding
	logic            keep;
	logic [30:0]     mx_abs, my_abs;
	logic [23:0]     mz_abs;
	logic [MN_W-1:0] mnum_x, mnum_y, mnum_z;

	always_comb begin
		keep = cv && ct_out.ok && !cxovf && !cyovf
		    && ({1'b0, cxq[CQ_W-1:8]} < COL_LIM)
		    && ({1'b0, cyq[CQ_W-1:8]} < ROW_LIM);
		mx_abs = ct_out.x[30] ? 31'(-ct_out.x) : 31'(ct_out.x);
		my_abs = ct_out.y[30] ? 31'(-ct_out.y) : 31'(ct_out.y);
		mz_abs = ct_out.zq[23] ? 24'(-ct_out.zq) : 24'(ct_out.zq);
		mnum_x = MN_W'({mx_abs[29:0], 5'b0}) + MROUND;
		mnum_y = MN_W'({my_abs[29:0], 5'b0}) + MROUND;
		mnum_z = MN_W'({mz_abs, 5'b0}) + MROUND;
	end

	// Stage 7: flag saturation, keep the numerators below the bound
	logic            vld_s7;
	logic [MR_W-1:0] rx_s7, ry_s7, rz_s7;
	logic            ox_s7, oy_s7, sx_s7, sy_s7, sz_s7;
	logic [17:0]     ccol_s7;
	logic [16:0]     crow_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else if (en) vld_s7 <= keep;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s7   <= mnum_x[MR_W-1:0];
			ry_s7   <= mnum_y[MR_W-1:0];
			rz_s7   <= mnum_z[MR_W-1:0];
			ox_s7   <= (mnum_x >= MSAT_BOUND);
			oy_s7   <= (mnum_y >= MSAT_BOUND);
			sx_s7   <= ct_out.x[30];
			sy_s7   <= ct_out.y[30];
			sz_s7   <= ct_out.zq[23];
			ccol_s7 <= cxq[17:0];
			crow_s7 <= cyq[16:0];
		end
	end

	// Stage 8: quotient by 125 through the reciprocal multiply
	logic [MP_W-1:0] prod_x, prod_y, prod_z;

	always_comb begin
		prod_x = MP_W'(rx_s7) * MP_W'(MREC);
		prod_y = MP_W'(ry_s7) * MP_W'(MREC);
		prod_z = MP_W'(rz_s7) * MP_W'(MREC);
	end

	logic            vld_s8;
	logic [MQ_W-1:0] mxq_s8, myq_s8, mzq_s8;
	logic            ox_s8, oy_s8, sx_s8, sy_s8, sz_s8;
	logic [17:0]     ccol_s8;
	logic [16:0]     crow_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else if (en) vld_s8 <= vld_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mxq_s8  <= prod_x[MREC_SH +: MQ_W];
			myq_s8  <= prod_y[MREC_SH +: MQ_W];
			mzq_s8  <= prod_z[MREC_SH +: MQ_W];
			ox_s8   <= ox_s7;
			oy_s8   <= oy_s7;
			sx_s8   <= sx_s7;
			sy_s8   <= sy_s7;
			sz_s8   <= sz_s7;
			ccol_s8 <= ccol_s7;
			crow_s8 <= crow_s7;
		end
	end

	// Saturate metric x and y to 24 bits; z always fits
	always_comb begin
		if (!sx_s8) begin
			out_item.point_x = (ox_s8 || mxq_s8[MQ_W-1]) ? 24'sh7FFFFF : $signed(mxq_s8);
		end else begin
			out_item.point_x = (ox_s8 || (mxq_s8 > 24'h800000)) ? 24'sh800000
			                 : $signed(-mxq_s8);
		end
		if (!sy_s8) begin
			out_item.point_y = (oy_s8 || myq_s8[MQ_W-1]) ? 24'sh7FFFFF : $signed(myq_s8);
		end else begin
			out_item.point_y = (oy_s8 || (myq_s8 > 24'h800000)) ? 24'sh800000
			                 : $signed(-myq_s8);
		end
		out_item.point_z   = sz_s8 ? $signed(-mzq_s8) : $signed(mzq_s8);
		out_item.color_col = ccol_s8;
		out_item.color_row = crow_s8;
	end

	assign out_wr = vld_s8 && en;

	dtc_fifo #(
		.W     ($bits(out_item_t)),
		.DEPTH (Q_DEPTH)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (out_wr),
		.wdata  (out_item),
		.rd     (pop),
		.rdata  (result),
		.full   (out_full),
		.empty  (empty)
	);

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s4) && $stable(vld_s6))
		else $error("pipeline moved while result queue was full");

	a_pop_enters: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> vld_s1)
		else $error("popped pixel did not enter the pipeline");

endmodule

[rtl/depth_to_color_registration.sv]
// Depth-to-color registration. Each depth pixel pushed in (column, row, signed depth in
// mm) is back-projected with the depth intrinsics, projected by the 3x4 color camera
// matrix and divided through, giving one result (metric point in Q7.16 m and color
// coordinates in Q.8) or none when the pixel is off the stride grid, out of the depth
// image, has no depth, the focal length is zero, the projected depth is not positive or
// the point falls outside the color image. The block takes one pixel every clock while
// its input queue is not full. Each queued pixel passes through the pipelined dividers:
// 31 register stages for the focal division and 21 for the color division, with the
// metric scaling done by a two-stage reciprocal multiply. A 4-beat input queue feeds the
// pipeline, and the whole pipeline holds while its 4-beat result queue is full.
// Configuration writes are always ready and must be made while no pixel is in flight.
//
// Top level: configuration registers, front part and back part.
// Depends on dtc_pkg, dtc_front and dtc_back.
module depth_to_color_registration #(
	parameter int STRIDE       = 2,
	parameter int DEPTH_WIDTH  = 640,
	parameter int DEPTH_HEIGHT = 480,
	parameter int COLOR_WIDTH  = 640,
	parameter int COLOR_HEIGHT = 480
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  dtc_pkg::in_item_t                pixel,
	output logic                             empty,
	input  logic                             pop,
	output dtc_pkg::out_item_t               result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dtc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [63:0]                      cfg_data
);
	import dtc_pkg::*;

	cfg_t     cfg_q;
	logic     q_pop, q_empty;
	in_item_t q_item;

	assign cfg_ready = 1'b1;

	// Capture configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEPTH_FOCAL: begin
					cfg_q.fx <= cfg_data[63:32];
					cfg_q.fy <= cfg_data[31:0];
				end
				REG_DEPTH_CENTER: begin
					cfg_q.cx <= cfg_data[63:32];
					cfg_q.cy <= cfg_data[31:0];
				end
				REG_PROJ_ROW0_LEFT: begin
					cfg_q.p[0][0] <= cfg_data[63:32];
					cfg_q.p[0][1] <= cfg_data[31:0];
				end
				REG_PROJ_ROW0_RIGHT: begin
					cfg_q.p[0][2] <= cfg_data[63:32];
					cfg_q.p[0][3] <= cfg_data[31:0];
				end
				REG_PROJ_ROW1_LEFT: begin
					cfg_q.p[1][0] <= cfg_data[63:32];
					cfg_q.p[1][1] <= cfg_data[31:0];
				end
				REG_PROJ_ROW1_RIGHT: begin
					cfg_q.p[1][2] <= cfg_data[63:32];
					cfg_q.p[1][3] <= cfg_data[31:0];
				end
				REG_PROJ_ROW2_LEFT: begin
					cfg_q.p[2][0] <= cfg_data[63:32];
					cfg_q.p[2][1] <= cfg_data[31:0];
				end
				REG_PROJ_ROW2_RIGHT: begin
					cfg_q.p[2][2] <= cfg_data[63:32];
					cfg_q.p[2][3] <= cfg_data[31:0];
				end
				default: begin
				end
			endcase
		end
	end

	dtc_front #(
		.STRIDE       (STRIDE),
		.DEPTH_WIDTH  (DEPTH_WIDTH),
		.DEPTH_HEIGHT (DEPTH_HEIGHT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.pixel   (pixel),
		.cfg     (cfg_q),
		.q_pop   (q_pop),
		.q_empty (q_empty),
		.q_item  (q_item)
	);

	dtc_back #(
		.COLOR_WIDTH  (COLOR_WIDTH),
		.COLOR_HEIGHT (COLOR_HEIGHT)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.q_item  (q_item),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

[bench/depth_to_color_registration_tb.sv]
// Self-checking bench for depth_to_color_registration: a directed table, then random
// pixel streams under several calibrations, checked against a local fixed-point model.
// Depends on dtc_pkg and the RTL of depth_to_color_registration.
`timescale 1ns / 1ps

module depth_to_color_registration_tb;
	import dtc_pkg::*;

	localparam int STRIDE       = 2;
	localparam int DEPTH_WIDTH  = 640;
	localparam int DEPTH_HEIGHT = 480;
	localparam int COLOR_WIDTH  = 640;
	localparam int COLOR_HEIGHT = 480;
	localparam int SETTLE       = 200;
	localparam int PHASE_ITEMS  = 140;
	localparam longint XY_LIMIT = 64'sd1073741823;

	typedef enum int {CFG_ZERO, CFG_CALIB, CFG_RAND, CFG_ONES} cfg_set_e;

	typedef struct {
		cfg_set_e cfg;
		int       col;
		int       row;
		int       depth;
		bit       no_point;  // known at a glance to give no result
	} pixel_row_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	in_item_t    pixel;
	logic        empty;
	logic        pop;
	out_item_t   result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [63:0] cfg_data;

	logic [63:0] calib_regs [8];
	out_item_t   expected_points[$];
	int          mismatches;
	int          idle_pct;
	int          stall_pct;

	depth_to_color_registration #(
		.STRIDE(STRIDE), .DEPTH_WIDTH(DEPTH_WIDTH), .DEPTH_HEIGHT(DEPTH_HEIGHT),
		.COLOR_WIDTH(COLOR_WIDTH), .COLOR_HEIGHT(COLOR_HEIGHT)
	) i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .pixel(pixel),
		.empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Signed division rounded to nearest, ties away from zero
	function automatic longint div_round(input longint num, input longint unsigned den);
		longint unsigned mag;
		longint unsigned q;
		mag = (num < 0) ? longint'(-num) : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint unproject(input longint pix, input longint unsigned center,
			input longint unsigned focal, input longint z);
		longint d;
		longint v;
		d = pix * 65536 - longint'(center);
		v = div_round(d * z * 256, focal);
		if (v > XY_LIMIT) v = XY_LIMIT;
		if (v < -XY_LIMIT) v = -XY_LIMIT;
		return v;
	endfunction

	function automatic longint sx32(input logic [31:0] v);
		return longint'($signed(v));
	endfunction

	function automatic longint camera_dot(input int r, input longint x, input longint y,
			input longint zq);
		logic [63:0] a;
		logic [63:0] b;
		a = calib_regs[2 + 2 * r];
		b = calib_regs[3 + 2 * r];
		return sx32(a[63:32]) * x + sx32(a[31:0]) * y + sx32(b[63:32]) * zq
			+ sx32(b[31:0]) * 256;
	endfunction

	// Floor of n/w in Q.8, by long division; fails outside [0, lim)
	function automatic bit color_coord(input longint n, input longint w, input int lim,
			output longint unsigned res);
		longint unsigned q;
		longint unsigned rem;
		longint unsigned frac;
		res = 0;
		if (n < 0) return 0;
		q = longint'(n) / longint'(w);
		if (q >= lim) return 0;
		rem = longint'(n) % longint'(w);
		frac = 0;
		for (int i = 0; i < 8; i++) begin
			rem = rem << 1;
			frac = frac << 1;
			if (rem >= w) begin
				rem = rem - w;
				frac = frac | 1;
			end
		end
		res = q * 256 + frac;
		return 1;
	endfunction

	function automatic logic [23:0] to_meters(input longint q8, input bit sat);
		longint m;
		m = div_round(q8 * 256, 1000);
		if (sat && m > 64'sd8388607) m = 64'sd8388607;
		if (sat && m < -64'sd8388608) m = -64'sd8388608;
		return m[23:0];
	endfunction

	// Register one pixel into the color camera; returns 0 when no point comes out
	function automatic bit register_pixel(input in_item_t p, output out_item_t r);
		longint unsigned fx, fy, cx, cy, ccol, crow;
		longint z, x, y, zq, px, py, pw;
		fx = calib_regs[0][63:32];
		fy = calib_regs[0][31:0];
		cx = calib_regs[1][63:32];
		cy = calib_regs[1][31:0];
		z = p.depth_raw;
		r = '0;
		if (p.pixel_col % STRIDE != 0 || p.pixel_row % STRIDE != 0) return 0;
		if (p.pixel_col >= DEPTH_WIDTH || p.pixel_row >= DEPTH_HEIGHT) return 0;
		if (z == 0 || fx == 0 || fy == 0) return 0;
		x = unproject(p.pixel_col, cx, fx, z);
		y = unproject(p.pixel_row, cy, fy, z);
		zq = z * 256;
		px = camera_dot(0, x, y, zq);
		py = camera_dot(1, x, y, zq);
		pw = camera_dot(2, x, y, zq);
		if (pw <= 0) return 0;
		if (!color_coord(px, pw, COLOR_WIDTH, ccol)) return 0;
		if (!color_coord(py, pw, COLOR_HEIGHT, crow)) return 0;
		r.point_x = to_meters(x, 1);
		r.point_y = to_meters(y, 1);
		r.point_z = to_meters(zq, 0);
		r.color_col = ccol[17:0];
		r.color_row = crow[16:0];
		return 1;
	endfunction

	// Send one pixel beat; starts and ends at a falling edge
	task automatic send_pixel(input in_item_t p);
		out_item_t r;
		while ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (full);
		if (register_pixel(p, r)) expected_points.insert(expected_points.size(), r);
		@(negedge clk);
	endtask

	// Hold the sender until the pipeline is empty
	task automatic drain();
		push <= 1'b0;
		wait (expected_points.size() == 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Write one register; valid stays high for the next write of a burst
	task automatic write_reg(input int idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		calib_regs[idx] = val;
		@(negedge clk);
	endtask

	// Load a full calibration: plain pinhole pair, random rig, or the extremes
	task automatic load_calibration(input cfg_set_e sel);
		logic [31:0] fx, fy, cx, cy, tx, ty, tz;
		logic [63:0] v [8];
		fx = 32'd38207075;
		fy = 32'd38185796;
		cx = 32'd20246017;
		cy = 32'd16132565;
		tx = '0;
		ty = '0;
		tz = '0;
		if (sel == CFG_RAND) begin
			fx = $urandom_range(900, 400) * 65536 + $urandom_range(65535);
			fy = $urandom_range(900, 400) * 65536 + $urandom_range(65535);
			cx = $urandom_range(400, 250) * 65536 + $urandom_range(65535);
			cy = $urandom_range(300, 180) * 65536 + $urandom_range(65535);
			tx = 32'($signed($urandom_range(200000)) - 100000) * 256;
			ty = 32'($signed($urandom_range(200000)) - 100000) * 256;
			tz = $urandom_range(65536 * 50);
		end
		v[REG_DEPTH_FOCAL]     = {fx, fy};
		v[REG_DEPTH_CENTER]    = {cx, cy};
		v[REG_PROJ_ROW0_LEFT]  = {fx, 32'd0};
		v[REG_PROJ_ROW0_RIGHT] = {cx, tx};
		v[REG_PROJ_ROW1_LEFT]  = {32'd0, fy};
		v[REG_PROJ_ROW1_RIGHT] = {cy, ty};
		v[REG_PROJ_ROW2_LEFT]  = 64'd0;
		v[REG_PROJ_ROW2_RIGHT] = {32'd65536, tz};
		for (int i = 0; i < 8; i++) begin
			if (sel == CFG_ZERO) v[i] = '0;
			if (sel == CFG_ONES) v[i] = '1;
			write_reg(i, v[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// Well-formed pixels mostly, raw noise on every bit for the rest
	function automatic in_item_t random_pixel();
		in_item_t p;
		if ($urandom_range(99) < 80) begin
			p.pixel_col = 10'($urandom_range(319) * 2);
			p.pixel_row = 9'($urandom_range(239) * 2);
			p.depth_raw = 16'($urandom_range(9000, 250));
		end else begin
			p.pixel_col = 10'($urandom);
			p.pixel_row = 9'($urandom);
			p.depth_raw = 16'($urandom);
		end
		return p;
	endfunction

	// Check each result beat against the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (expected_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %p", result);
			end else begin
				want = expected_points.pop_front();
				if (result.point_x !== want.point_x || result.point_y !== want.point_y ||
						result.point_z !== want.point_z ||
						result.color_col !== want.color_col ||
						result.color_row !== want.color_row) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, result);
				end
			end
		end
	end

	// Stall the result side at random
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			pop <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		pixel_row_t dir_rows [$];
		cfg_set_e   cur;
		in_item_t   p;
		arst_n = 1'b0;
		push = 1'b0;
		pixel = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		mismatches = 0;
		for (int i = 0; i < 8; i++) calib_regs[i] = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		dir_rows = '{
			'{CFG_ZERO,  320, 240,   1000, 1},  // zero focal length after reset
			'{CFG_ZERO,    0,   0,  32767, 1},
			'{CFG_CALIB, 320, 240,   1000, 0},
			'{CFG_CALIB,   0,   0,      1, 0},
			'{CFG_CALIB, 638, 478,  32767, 0},
			'{CFG_CALIB,   0,   0,  32767, 0},
			'{CFG_CALIB, 638,   0,    400, 0},
			'{CFG_CALIB,   2,   2,    800, 0},
			'{CFG_CALIB,   1,   0,   1000, 1},  // off the grid
			'{CFG_CALIB,   0,   1,   1000, 1},
			'{CFG_CALIB, 639, 479,   1000, 1},
			'{CFG_CALIB, 640,   0,   1000, 1},  // outside the depth image
			'{CFG_CALIB,   0, 480,   1000, 1},
			'{CFG_CALIB, 1022, 510,  1000, 1},
			'{CFG_CALIB, 1023, 511,  1000, 1},
			'{CFG_CALIB, 320, 240,      0, 1},  // no measurement
			'{CFG_CALIB, 320, 240,     -1, 1},  // negative depth projects behind
			'{CFG_CALIB, 320, 240, -32768, 1},
			'{CFG_ONES,  320, 240,  -1000, 0},
			'{CFG_ONES,    0,   0,   1000, 0},
			'{CFG_ONES,  638, 478, -32768, 0}
		};
		cur = CFG_ZERO;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].cfg != cur) begin
				drain();
				cur = dir_rows[i].cfg;
				load_calibration(cur);
			end
			p.pixel_col = 10'(dir_rows[i].col);
			p.pixel_row = 9'(dir_rows[i].row);
			p.depth_raw = 16'(dir_rows[i].depth);
			send_pixel(p);
			if (dir_rows[i].no_point) begin
				// drop the prediction: these rows must give nothing at all
				out_item_t r;
				if (register_pixel(p, r)) void'(expected_points.pop_back());
			end
		end

		// Random phases over calibrations, idling and stall patterns
		for (int ph = 0; ph < 8; ph++) begin
			cfg_set_e sel;
			drain();
			case (ph)
				2: sel = CFG_ONES;
				5: sel = CFG_ZERO;
				0, 4, 7: sel = CFG_CALIB;
				default: sel = CFG_RAND;
			endcase
			load_calibration(sel);
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 66; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 66; end
				default: begin idle_pct = 26; stall_pct = 26; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) send_pixel(random_pixel());
		end
		drain();

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[files.f]
rtl/dtc_pkg.sv
rtl/dtc_fifo.sv
rtl/dtc_div.sv
rtl/dtc_front.sv
rtl/dtc_back.sv
rtl/depth_to_color_registration.sv
bench/depth_to_color_registration_tb.sv
